/* rtl/cycle_timer_event_scheduler_top_defines.svh */
// Assertion macros for the cycle timer event scheduler checker.
// No dependencies; included by the checker file only.
`ifndef CYCLE_TIMER_EVENT_SCHEDULER_TOP_DEFINES_SVH
`define CYCLE_TIMER_EVENT_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define CTES_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ctes check failed");

// next-cycle implication
`define CTES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ctes check failed");

`endif

/* rtl/ctes_pkg.sv */
// Shared types and constants of the cycle timer event scheduler.
// No dependencies.
`default_nettype none
package ctes_pkg;

  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned DIV_STEPS   = 64;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_STOP    = 2'd1,
    KIND_READ    = 2'd2,
    KIND_ADVANCE = 2'd3
  } kind_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_REJ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARM,
    ST_READ,
    ST_DIV,
    ST_SRD,
    ST_SCMP,
    ST_SEND,
    ST_FIRE,
    ST_RMUL,
    ST_RWR,
    ST_NEXT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        fired;
    logic [2:0]  fired_slot;
    logic [31:0] read_value;
    logic        status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        dl_en;
    logic        cfg_en;
    logic [63:0] deadline;
    logic [31:0] count;
    logic [31:0] rate;
  } mem_wr_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] count;
    logic [31:0] rate;
  } mem_rd_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

/* rtl/ctes_in_if.sv */
// Input channel of the scheduler: one command item per handshake.
// No dependencies.
`default_nettype none
interface ctes_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  slot;
  logic [31:0] tick_count;
  logic [31:0] tick_rate;
  logic        single_shot;
  logic [31:0] elapsed;

  modport source (output valid, kind, slot, tick_count, tick_rate, single_shot, elapsed,
                  input ready);
  modport sink (input valid, kind, slot, tick_count, tick_rate, single_shot, elapsed,
                output ready);
endinterface
`default_nettype wire

/* rtl/ctes_out_if.sv */
// Result channel of the scheduler: one result item per handshake.
// No dependencies.
`default_nettype none
interface ctes_out_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [2:0]  fired_slot;
  logic [31:0] read_value;
  logic        status;
  logic        last;

  modport source (output valid, fired, fired_slot, read_value, status, last, input ready);
  modport sink (input valid, fired, fired_slot, read_value, status, last, output ready);
endinterface
`default_nettype wire

/* rtl/ctes_slot_mem.sv */
// Per-slot deadline, count and rate storage, one write and one registered read port.
// Depends on ctes_pkg.
`default_nettype none
module ctes_slot_mem #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned SW    = 3
) (
  input  wire logic               clk_i,
  input  wire ctes_pkg::mem_wr_t  wr_i,
  input  wire logic [SW-1:0]      wr_addr_i,
  input  wire logic [SW-1:0]      rd_addr_i,
  output ctes_pkg::mem_rd_t       rd_o
);
  import ctes_pkg::*;

  logic [63:0] dl_mem  [SLOTS];
  logic [31:0] cnt_mem [SLOTS];
  logic [31:0] rt_mem  [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.dl_en) begin
      dl_mem[wr_addr_i] <= wr_i.deadline;
    end
    if (wr_i.cfg_en) begin
      cnt_mem[wr_addr_i] <= wr_i.count;
      rt_mem[wr_addr_i]  <= wr_i.rate;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_o.deadline <= dl_mem[rd_addr_i];
    rd_o.count    <= cnt_mem[rd_addr_i];
    rd_o.rate     <= rt_mem[rd_addr_i];
  end
endmodule
`default_nettype wire

/* rtl/ctes_div.sv */
// Restoring 64-by-32 divider, one quotient bit per cycle; low 32 quotient bits out.
// Depends on ctes_pkg.
`default_nettype none
module ctes_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctes_pkg::div_req_t req_i,
  output logic                    done_o,
  output logic [31:0]             quot_o
);
  import ctes_pkg::*;

  localparam int unsigned CW = $clog2(DIV_STEPS + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [63:0]   dvd_q, dvd_d;
  logic [31:0]   dvs_q, dvs_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   quo_q, quo_d;
  logic [32:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[63]};
    ge     = rem_sh >= {1'b0, dvs_q};
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      cnt_d = CW'(DIV_STEPS);
      dvd_d = req_i.dividend;
      dvs_d = req_i.divisor;
      rem_d = '0;
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
      dvd_d  = {dvd_q[62:0], 1'b0};
      rem_d  = ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
      quo_d  = {quo_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

/* rtl/cycle_timer_event_scheduler_top.sv */
// Cycle timer event scheduler top: sequencer, slot state, multiplier and result register.
// Depends on ctes_pkg, ctes_in_if, ctes_out_if, ctes_slot_mem and ctes_div.
//
// Usage: commands enter on in_ch (start, stop, read remaining, advance time) and
// results leave on out_ch, each with last set on the final result of a command.
// in_ch.ready is high only while the sequencer is idle; one command at a time.
// Start passes through ST_ARM to ST_EMIT and stop goes straight to ST_EMIT. Read waits on the
// bit-serial 64-by-32 divider. Advance scans the slots through the single slot
// memory read port, each slot read in ST_SRD and compared in ST_SCMP, once per
// fired slot (at most 8) plus once more when fewer than 8 fire; a periodic slot
// that re-arms also passes through ST_RMUL and ST_RWR.
// Results pass through one output register; while out_ch stalls the sequencer
// holds at its next result. An idle sequencer still takes one more command,
// which then holds at its own result until the output register frees.
// Reset clears the cycle count and all armed and started flags at once; no
// clearing pass is needed.
`default_nettype none
module cycle_timer_event_scheduler_top #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ctes_in_if.sink     in_ch,
  ctes_out_if.source  out_ch
);
  import ctes_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  state_e           state_q, state_d, ret_q, ret_d;
  kind_e            kind_in;
  logic [SW-1:0]    idx_q, idx_d;
  logic [31:0]      cnt_q, cnt_d, rate_q, rate_d;
  logic             once_q, once_d;
  logic [63:0]      now_q, now_d;
  logic [63:0]      prod_q, prod_d;
  logic [SLOTS-1:0] armed_q, armed_d, oneshot_q, oneshot_d, started_q, started_d;
  logic [SLOTS-1:0] done_q, done_d;
  logic [SW-1:0]    scan_q, scan_d, best_q, best_d, pend_q, pend_d;
  logic             bvld_q, bvld_d, pvld_q, pvld_d;
  logic [63:0]      bdl_q, bdl_d;
  logic [NW-1:0]    n_q, n_d;
  res_t             res_q, res_d, out_q, out_d;
  logic             out_vld_q, out_vld_d;
  logic             in_acc, in_range, can_load;
  logic [SW-1:0]    rd_addr, wr_addr;
  mem_wr_t          mem_wr;
  mem_rd_t          mem_rd;
  div_req_t         div_req;
  logic             div_done;
  logic [31:0]      div_quot;
  logic [31:0]      mul_a, mul_b;

  ctes_slot_mem #(.SLOTS(SLOTS), .SW(SW)) u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .wr_addr_i (wr_addr),
    .rd_addr_i (rd_addr),
    .rd_o      (mem_rd)
  );

  ctes_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign kind_in     = kind_e'(in_ch.kind);
  assign in_range    = {4'b0, in_ch.slot} < 7'(SLOTS);
  assign can_load    = !out_vld_q || out_ch.ready;

  always_comb begin
    unique case (state_q)
      ST_IDLE:                  rd_addr = SW'(in_ch.slot);
      ST_SRD:                   rd_addr = scan_q;
      ST_FIRE, ST_RMUL, ST_RWR: rd_addr = best_q;
      default:                  rd_addr = idx_q;
    endcase
  end

  assign mul_a = (state_q == ST_IDLE) ? in_ch.tick_count : mem_rd.count;
  assign mul_b = (state_q == ST_IDLE) ? in_ch.tick_rate  : mem_rd.rate;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    rate_d    = rate_q;
    once_d    = once_q;
    now_d     = now_q;
    prod_d    = 64'(mul_a) * 64'(mul_b);
    armed_d   = armed_q;
    oneshot_d = oneshot_q;
    started_d = started_q;
    done_d    = done_q;
    scan_d    = scan_q;
    best_d    = best_q;
    bvld_d    = bvld_q;
    bdl_d     = bdl_q;
    pend_d    = pend_q;
    pvld_d    = pvld_q;
    n_d       = n_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ch.ready;
    mem_wr    = '0;
    wr_addr   = idx_q;
    div_req   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d  = SW'(in_ch.slot);
          cnt_d  = in_ch.tick_count;
          rate_d = in_ch.tick_rate;
          once_d = in_ch.single_shot;
          res_d  = '{fired: 1'b0, fired_slot: 3'd0, read_value: 32'd0,
                     status: STATUS_OK, last: 1'b1};
          ret_d  = ST_IDLE;
          if (kind_in == KIND_ADVANCE) begin
            now_d   = now_q + 64'(in_ch.elapsed);
            done_d  = '0;
            n_d     = '0;
            pvld_d  = 1'b0;
            scan_d  = '0;
            bvld_d  = 1'b0;
            state_d = ST_SRD;
          end else if (!in_range) begin
            state_d = ST_EMIT;
          end else begin
            unique case (kind_in)
              KIND_START: begin
                if (in_ch.tick_count == '0 || in_ch.tick_rate == '0) begin
                  res_d.status = STATUS_REJ;
                  state_d      = ST_EMIT;
                end else begin
                  state_d = ST_ARM;
                end
              end
              KIND_STOP: begin
                armed_d[SW'(in_ch.slot)] = 1'b0;
                state_d = ST_EMIT;
              end
              default: state_d = ST_READ;
            endcase
          end
        end
      end
      ST_ARM: begin
        mem_wr.dl_en    = 1'b1;
        mem_wr.cfg_en   = 1'b1;
        mem_wr.deadline = now_q + prod_q;
        mem_wr.count    = cnt_q;
        mem_wr.rate     = rate_q;
        armed_d[idx_q]   = 1'b1;
        started_d[idx_q] = 1'b1;
        oneshot_d[idx_q] = once_q;
        state_d = ST_EMIT;
      end
      ST_READ: begin
        if (armed_q[idx_q]) begin
          div_req.start    = 1'b1;
          div_req.dividend = mem_rd.deadline - now_q;
          div_req.divisor  = mem_rd.rate;
          state_d = ST_DIV;
        end else begin
          res_d.read_value = started_q[idx_q] ? mem_rd.count : 32'd0;
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_d.read_value = div_quot;
          state_d = ST_EMIT;
        end
      end
      ST_SRD: state_d = ST_SCMP;
      ST_SCMP: begin
        if (armed_q[scan_q] && !done_q[scan_q] && mem_rd.deadline <= now_q &&
            (!bvld_q || mem_rd.deadline < bdl_q)) begin
          bvld_d = 1'b1;
          best_d = scan_q;
          bdl_d  = mem_rd.deadline;
        end
        if (scan_q == SW'(SLOTS - 1)) begin
          state_d = ST_SEND;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_SEND: begin
        res_d = '{fired: pvld_q, fired_slot: pvld_q ? 3'(pend_q) : 3'd0,
                  read_value: 32'd0, status: STATUS_OK, last: !bvld_q};
        if (!bvld_q) begin
          ret_d   = ST_IDLE;
          state_d = ST_EMIT;
        end else if (pvld_q) begin
          ret_d   = ST_FIRE;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_FIRE;
        end
      end
      ST_FIRE: begin
        pend_d = best_q;
        pvld_d = 1'b1;
        n_d    = n_q + 1'b1;
        done_d[best_q] = 1'b1;
        if (oneshot_q[best_q]) begin
          armed_d[best_q] = 1'b0;
          state_d = ST_NEXT;
        end else begin
          state_d = ST_RMUL;
        end
      end
      ST_RMUL: state_d = ST_RWR;
      ST_RWR: begin
        wr_addr         = best_q;
        mem_wr.dl_en    = 1'b1;
        mem_wr.deadline = now_q + prod_q;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (n_q == NW'(MAX_RESULTS)) begin
          res_d = '{fired: 1'b1, fired_slot: 3'(pend_q), read_value: 32'd0,
                    status: STATUS_OK, last: 1'b1};
          ret_d   = ST_IDLE;
          state_d = ST_EMIT;
        end else begin
          scan_d  = '0;
          bvld_d  = 1'b0;
          state_d = ST_SRD;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ret_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      now_q     <= '0;
      armed_q   <= '0;
      oneshot_q <= '0;
      started_q <= '0;
      out_vld_q <= 1'b0;
      bvld_q    <= 1'b0;
      pvld_q    <= 1'b0;
      n_q       <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      now_q     <= now_d;
      armed_q   <= armed_d;
      oneshot_q <= oneshot_d;
      started_q <= started_d;
      out_vld_q <= out_vld_d;
      bvld_q    <= bvld_d;
      pvld_q    <= pvld_d;
      n_q       <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    rate_q <= rate_d;
    once_q <= once_d;
    prod_q <= prod_d;
    done_q <= done_d;
    scan_q <= scan_d;
    best_q <= best_d;
    bdl_q  <= bdl_d;
    pend_q <= pend_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_ch.valid      = out_vld_q;
  assign out_ch.fired      = out_q.fired;
  assign out_ch.fired_slot = out_q.fired_slot;
  assign out_ch.read_value = out_q.read_value;
  assign out_ch.status     = out_q.status;
  assign out_ch.last       = out_q.last;
endmodule
`default_nettype wire

/* rtl/ctes_checker.sv */
// Port-level checks of the scheduler and their binding to the top level.
// Depends on cycle_timer_event_scheduler_top_defines.svh.
`default_nettype none
`include "cycle_timer_event_scheduler_top_defines.svh"
module ctes_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        out_fired_i,
  input wire logic [31:0] out_rval_i,
  input wire logic        out_status_i,
  input wire logic        out_last_i
);
  `CTES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_rval_i) && $stable(out_last_i) && $stable(out_fired_i))
  `CTES_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `CTES_ASSERT_NOW(a_more_only_fired, clk_i, rst_ni, out_valid_i && !out_last_i, out_fired_i)
  `CTES_ASSERT_NOW(a_fired_clean, clk_i, rst_ni, out_valid_i && out_fired_i, out_rval_i == 32'd0 && out_status_i == 1'b0)
endmodule

bind cycle_timer_event_scheduler_top ctes_checker u_ctes_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_fired_i  (out_ch.fired),
  .out_rval_i   (out_ch.read_value),
  .out_status_i (out_ch.status),
  .out_last_i   (out_ch.last)
);
`default_nettype wire

/* tb/tb_cycle_timer_event_scheduler_top.sv */
// Self-checking testbench for cycle_timer_event_scheduler_top: random and directed commands,
// predicted in-line and compared item by item with random stalls on both channels.
// Depends on ctes_pkg, ctes_in_if, ctes_out_if and the scheduler RTL.
`default_nettype none
module tb_cycle_timer_event_scheduler_top;
  import ctes_pkg::*;

  localparam int unsigned NSLOT      = 8;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned RAND_ITEMS = 310;
  localparam int unsigned DRAIN_CYC  = 400;
  localparam int unsigned CHOKE_AT   = 150;
  localparam int unsigned CHOKE_LEN  = 600;

  typedef struct {
    kind_e       kind;
    logic [2:0]  slot;
    logic [31:0] tick_count;
    logic [31:0] tick_rate;
    logic        single_shot;
    logic [31:0] elapsed;
  } cmd_t;

  logic clk_i;
  logic rst_ni;

  ctes_in_if  in_ch();
  ctes_out_if out_ch();

  cycle_timer_event_scheduler_top #(.SLOTS(NSLOT)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // timer state mirror
  logic [63:0] now_q;
  logic [63:0] due_q   [NSLOT];
  logic [31:0] units_q [NSLOT];
  logic [31:0] period_q[NSLOT];
  logic        live_q  [NSLOT];
  logic        once_q  [NSLOT];

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  cmd_t cur;

  int unsigned gap_left, hold_left, choke_left, cycles;
  int unsigned cmds_taken, res_seen, mismatches, fires, reads, rejects;
  int unsigned n_cmds;
  bit          choke_done;

  function automatic void schedule(cmd_t c);
    res_t        r;
    logic [7:0]  done;
    int          best;
    int unsigned n;
    r = '0;
    if (c.kind == KIND_ADVANCE) begin
      done = '0;
      n = 0;
      now_q = now_q + 64'(c.elapsed);
      while (n < MAX_RESULTS) begin
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (live_q[i] && !done[i] && due_q[i] <= now_q &&
              (best < 0 || due_q[i] < due_q[best])) best = i;
        end
        if (best < 0) break;
        done[best] = 1'b1;
        r = '0;
        r.fired = 1'b1;
        r.fired_slot = 3'(best);
        expected_res.push_back(r);
        n++;
        fires++;
        if (once_q[best]) live_q[best] = 1'b0;
        else due_q[best] = now_q + 64'(units_q[best]) * 64'(period_q[best]);
      end
      if (n == 0) expected_res.push_back('0);
    end else begin
      case (c.kind)
        KIND_START: begin
          if (c.tick_count == 0 || c.tick_rate == 0) begin
            r.status = STATUS_REJ;
            rejects++;
          end else begin
            units_q[c.slot]  = c.tick_count;
            period_q[c.slot] = c.tick_rate;
            once_q[c.slot]   = c.single_shot;
            due_q[c.slot]    = now_q + 64'(c.tick_count) * 64'(c.tick_rate);
            live_q[c.slot]   = 1'b1;
          end
        end
        KIND_STOP: live_q[c.slot] = 1'b0;
        default: begin
          reads++;
          if (live_q[c.slot] && period_q[c.slot] != 0)
            r.read_value = 32'((due_q[c.slot] - now_q) / 64'(period_q[c.slot]));
          else
            r.read_value = units_q[c.slot];
        end
      endcase
      expected_res.push_back(r);
    end
    expected_res[expected_res.size() - 1].last = 1'b1;
  endfunction

  function automatic cmd_t mk(kind_e k, int unsigned s, logic [31:0] cnt, logic [31:0] rate,
                              logic once, logic [31:0] el);
    cmd_t c;
    c.kind = k;
    c.slot = 3'(s);
    c.tick_count = cnt;
    c.tick_rate = rate;
    c.single_shot = once;
    c.elapsed = el;
    return c;
  endfunction

  function automatic logic [31:0] pick_small(int unsigned hi);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5) return 32'd0;
    if (p < 15) return $urandom;
    return $urandom_range(1, hi);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned p;
    c.slot = 3'($urandom_range(0, 7));
    c.tick_count = $urandom;
    c.tick_rate = $urandom;
    c.single_shot = 1'($urandom);
    c.elapsed = $urandom;
    p = $urandom_range(0, 99);
    if (p < 35) begin
      c.kind = KIND_START;
      c.tick_count = pick_small(24);
      c.tick_rate = pick_small(8);
    end else if (p < 70) begin
      c.kind = KIND_ADVANCE;
      if ($urandom_range(0, 99) < 85) c.elapsed = $urandom_range(0, 60);
    end else if (p < 90) begin
      c.kind = KIND_READ;
    end else begin
      c.kind = KIND_STOP;
    end
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_res.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= KIND_START;
      in_ch.slot <= '0;
      in_ch.tick_count <= '0;
      in_ch.tick_rate <= '0;
      in_ch.single_shot <= 1'b0;
      in_ch.elapsed <= '0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        schedule(cur);
        cmds_taken <= cmds_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur = pending_cmds.pop_front();
          in_ch.kind <= cur.kind;
          in_ch.slot <= cur.slot;
          in_ch.tick_count <= cur.tick_count;
          in_ch.tick_rate <= cur.tick_rate;
          in_ch.single_shot <= cur.single_shot;
          in_ch.elapsed <= cur.elapsed;
          in_ch.valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off on the result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      choke_left <= 0;
      choke_done <= 1'b0;
    end else if (!choke_done && cmds_taken >= CHOKE_AT) begin
      choke_left <= CHOKE_LEN;
      choke_done <= 1'b1;
    end else if (choke_left > 0) begin
      choke_left <= choke_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    int unsigned p;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.fired = out_ch.fired;
        got.fired_slot = out_ch.fired_slot;
        got.read_value = out_ch.read_value;
        got.status = out_ch.status;
        got.last = out_ch.last;
        res_seen <= res_seen + 1;
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_res.pop_front();
          if (got.fired !== want.fired || got.fired_slot !== want.fired_slot ||
              got.read_value !== want.read_value || got.status !== want.status ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      p = $urandom_range(0, 99);
      if (choke_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (p < 75) begin
        out_ch.ready <= 1'b1;
      end else if (p < 96) begin
        hold_left <= $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        hold_left <= $urandom_range(10, 40);
        out_ch.ready <= 1'b0;
      end
    end
  end

  initial begin
    now_q = '0;
    for (int i = 0; i < NSLOT; i++) begin
      due_q[i] = '0;
      units_q[i] = '0;
      period_q[i] = '0;
      live_q[i] = 1'b0;
      once_q[i] = 1'b0;
    end
    cycles = 0;
    cmds_taken = 0;
    res_seen = 0;
    mismatches = 0;
    fires = 0;
    reads = 0;
    rejects = 0;
    rst_ni = 1'b0;

    // never-started read, idle advance, rejected starts
    pending_cmds.push_back(mk(KIND_READ, 3, '0, '0, 1'b0, '0));
    pending_cmds.push_back(mk(KIND_ADVANCE, 0, '1, '1, 1'b1, 0));
    pending_cmds.push_back(mk(KIND_START, 0, 0, 5, 1'b1, '1));
    pending_cmds.push_back(mk(KIND_START, 1, 5, 0, 1'b0, '1));
    // extreme deadline, read of armed and of stopped slot
    pending_cmds.push_back(mk(KIND_START, 7, '1, '1, 1'b0, '1));
    pending_cmds.push_back(mk(KIND_READ, 7, '0, '0, 1'b0, '0));
    pending_cmds.push_back(mk(KIND_STOP, 7, '0, '0, 1'b0, '0));
    pending_cmds.push_back(mk(KIND_READ, 7, '0, '0, 1'b0, '0));
    // all slots due together: ties by slot index, mixed one-shot and periodic
    for (int i = NSLOT - 1; i >= 0; i--)
      pending_cmds.push_back(mk(KIND_START, i, 2, 3, 1'(i & 1), 0));
    pending_cmds.push_back(mk(KIND_READ, 2, '0, '0, 1'b0, '0));
    pending_cmds.push_back(mk(KIND_ADVANCE, 0, 0, 0, 1'b0, 6));
    pending_cmds.push_back(mk(KIND_ADVANCE, 0, 0, 0, 1'b0, 6));
    // restart an armed slot, then a huge advance
    pending_cmds.push_back(mk(KIND_START, 0, 1, 1, 1'b1, 0));
    pending_cmds.push_back(mk(KIND_START, 0, 4, 1, 1'b1, 0));
    pending_cmds.push_back(mk(KIND_ADVANCE, 0, 0, 0, 1'b0, 3));
    pending_cmds.push_back(mk(KIND_ADVANCE, 0, 0, 0, 1'b0, '1));
    for (int i = 0; i < RAND_ITEMS; i++) pending_cmds.push_back(random_cmd());
    n_cmds = pending_cmds.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (cmds_taken == n_cmds && expected_res.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("%0d commands, %0d results checked: %0d expiries, %0d reads, %0d rejected starts",
             cmds_taken, res_seen, fires, reads, rejects);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
